FILE: src/aes_pkg.sv
// ----------------------------------------------------------------------------
// aes_pkg
// Shared types, constants and byte-level functions for the AES-128 pipeline.
// ----------------------------------------------------------------------------
package aes_pkg;

    localparam int unsigned NumRounds = 10;

    typedef logic [127:0] t_block;
    typedef logic [7:0]   t_byte;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        REG_KEY_HIGH = 1'b0,
        REG_KEY_LOW  = 1'b1
    } t_reg_idx;

    localparam t_byte SBOX [256] = '{
        8'h63,8'h7C,8'h77,8'h7B,8'hF2,8'h6B,8'h6F,8'hC5,8'h30,8'h01,8'h67,8'h2B,8'hFE,8'hD7,8'hAB,8'h76,
        8'hCA,8'h82,8'hC9,8'h7D,8'hFA,8'h59,8'h47,8'hF0,8'hAD,8'hD4,8'hA2,8'hAF,8'h9C,8'hA4,8'h72,8'hC0,
        8'hB7,8'hFD,8'h93,8'h26,8'h36,8'h3F,8'hF7,8'hCC,8'h34,8'hA5,8'hE5,8'hF1,8'h71,8'hD8,8'h31,8'h15,
        8'h04,8'hC7,8'h23,8'hC3,8'h18,8'h96,8'h05,8'h9A,8'h07,8'h12,8'h80,8'hE2,8'hEB,8'h27,8'hB2,8'h75,
        8'h09,8'h83,8'h2C,8'h1A,8'h1B,8'h6E,8'h5A,8'hA0,8'h52,8'h3B,8'hD6,8'hB3,8'h29,8'hE3,8'h2F,8'h84,
        8'h53,8'hD1,8'h00,8'hED,8'h20,8'hFC,8'hB1,8'h5B,8'h6A,8'hCB,8'hBE,8'h39,8'h4A,8'h4C,8'h58,8'hCF,
        8'hD0,8'hEF,8'hAA,8'hFB,8'h43,8'h4D,8'h33,8'h85,8'h45,8'hF9,8'h02,8'h7F,8'h50,8'h3C,8'h9F,8'hA8,
        8'h51,8'hA3,8'h40,8'h8F,8'h92,8'h9D,8'h38,8'hF5,8'hBC,8'hB6,8'hDA,8'h21,8'h10,8'hFF,8'hF3,8'hD2,
        8'hCD,8'h0C,8'h13,8'hEC,8'h5F,8'h97,8'h44,8'h17,8'hC4,8'hA7,8'h7E,8'h3D,8'h64,8'h5D,8'h19,8'h73,
        8'h60,8'h81,8'h4F,8'hDC,8'h22,8'h2A,8'h90,8'h88,8'h46,8'hEE,8'hB8,8'h14,8'hDE,8'h5E,8'h0B,8'hDB,
        8'hE0,8'h32,8'h3A,8'h0A,8'h49,8'h06,8'h24,8'h5C,8'hC2,8'hD3,8'hAC,8'h62,8'h91,8'h95,8'hE4,8'h79,
        8'hE7,8'hC8,8'h37,8'h6D,8'h8D,8'hD5,8'h4E,8'hA9,8'h6C,8'h56,8'hF4,8'hEA,8'h65,8'h7A,8'hAE,8'h08,
        8'hBA,8'h78,8'h25,8'h2E,8'h1C,8'hA6,8'hB4,8'hC6,8'hE8,8'hDD,8'h74,8'h1F,8'h4B,8'hBD,8'h8B,8'h8A,
        8'h70,8'h3E,8'hB5,8'h66,8'h48,8'h03,8'hF6,8'h0E,8'h61,8'h35,8'h57,8'hB9,8'h86,8'hC1,8'h1D,8'h9E,
        8'hE1,8'hF8,8'h98,8'h11,8'h69,8'hD9,8'h8E,8'h94,8'h9B,8'h1E,8'h87,8'hE9,8'hCE,8'h55,8'h28,8'hDF,
        8'h8C,8'hA1,8'h89,8'h0D,8'hBF,8'hE6,8'h42,8'h68,8'h41,8'h99,8'h2D,8'h0F,8'hB0,8'h54,8'hBB,8'h16
    };

    // Round constants for rounds 1..10 (index 0 is round 1).
    localparam t_byte RCON [NumRounds] = '{
        8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1B, 8'h36
    };

    // Byte k of the block sits at bits [127-8k -: 8].
    function automatic t_byte get_byte(input t_block b, input int unsigned k);
        return b[127 - 8 * k -: 8];
    endfunction

    function automatic t_byte xtime(input t_byte v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1B : 8'h00);
    endfunction

    function automatic t_block sub_shift(input t_block s);
        t_block t;
        for (int c = 0; c < 4; c++) begin
            for (int r = 0; r < 4; r++) begin
                t[127 - 8 * (c * 4 + r) -: 8] = SBOX[get_byte(s, ((c + r) % 4) * 4 + r)];
            end
        end
        return t;
    endfunction

    function automatic t_block mix_columns(input t_block s);
        t_block t;
        t_byte  a0, a1, a2, a3, b0, b1, b2, b3;
        for (int c = 0; c < 4; c++) begin
            a0 = get_byte(s, c * 4);
            a1 = get_byte(s, c * 4 + 1);
            a2 = get_byte(s, c * 4 + 2);
            a3 = get_byte(s, c * 4 + 3);
            b0 = xtime(a0);
            b1 = xtime(a1);
            b2 = xtime(a2);
            b3 = xtime(a3);
            t[127 - 8 * (c * 4)     -: 8] = b0 ^ b1 ^ a1 ^ a2 ^ a3;
            t[127 - 8 * (c * 4 + 1) -: 8] = a0 ^ b1 ^ b2 ^ a2 ^ a3;
            t[127 - 8 * (c * 4 + 2) -: 8] = a0 ^ a1 ^ b2 ^ b3 ^ a3;
            t[127 - 8 * (c * 4 + 3) -: 8] = b0 ^ a0 ^ a1 ^ a2 ^ b3;
        end
        return t;
    endfunction

    function automatic t_block next_key(input t_block rk, input t_byte rcon);
        logic [31:0] w0, w1, w2, w3, tw;
        w0 = rk[127:96];
        w1 = rk[95:64];
        w2 = rk[63:32];
        w3 = rk[31:0];
        tw = {SBOX[w3[23:16]] ^ rcon, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
        w0 = w0 ^ tw;
        w1 = w1 ^ w0;
        w2 = w2 ^ w1;
        w3 = w3 ^ w2;
        return {w0, w1, w2, w3};
    endfunction

endpackage

FILE: src/aes_round.sv
// ----------------------------------------------------------------------------
// aes_round
// One registered AES round: SubBytes, ShiftRows, optional MixColumns, key
// expansion and AddRoundKey, with a valid bit traveling alongside.
// ----------------------------------------------------------------------------
module aes_round #(
    parameter logic [7:0] RCON_VAL  = 8'h01,
    parameter bit         FINAL_RND = 1'b0
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    input  aes_pkg::t_block i_state,
    input  aes_pkg::t_block i_key,
    output logic           o_valid,
    output aes_pkg::t_block o_state,
    output aes_pkg::t_block o_key
);
    import aes_pkg::*;

    logic   r_valid;
    t_block r_state, r_key;
    t_block n_state, n_key, w_sub;

    always_comb begin
        w_sub   = sub_shift(i_state);
        n_key   = next_key(i_key, RCON_VAL);
        n_state = (FINAL_RND ? w_sub : mix_columns(w_sub)) ^ n_key;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
        r_state <= n_state;
        r_key   <= n_key;
    end

    assign o_valid = r_valid;
    assign o_state = r_state;
    assign o_key   = r_key;
endmodule

FILE: src/aes128_block_encrypt_top.sv
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top
// AES-128 block encryption, fully unrolled into a round pipeline.
// ----------------------------------------------------------------------------
// An item is accepted on any cycle with i_start high; busy is never raised.
// Each ciphertext appears on o_cipher_* with o_done high for one cycle, once
// its item has passed the pipeline registers: one for the initial key add and
// one per round in the ten round stages. One item per cycle is sustained, and
// results leave in acceptance order. The receiver cannot stall the pipeline.
// The key is held in two 64-bit APB registers and must only change while no
// item is in flight.
module aes128_block_encrypt_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [63:0] i_block_high,
    input  logic [63:0] i_block_low,
    output logic        o_done,
    output logic [63:0] o_cipher_high,
    output logic [63:0] o_cipher_low,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import aes_pkg::*;

    logic [63:0] r_key_high, r_key_low;
    logic        w_wr;
    logic        w_addr_ok;
    t_reg_idx    w_idx;

    assign pready    = 1'b1;
    assign o_busy    = 1'b0;
    assign w_idx     = t_reg_idx'(paddr[3]);
    assign w_addr_ok = (paddr[2:0] == 3'd0);
    assign w_wr      = psel && penable && pwrite && w_addr_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_high <= '0;
            r_key_low  <= '0;
        end else if (w_wr) begin
            unique case (w_idx)
                REG_KEY_HIGH: r_key_high <= pwdata;
                REG_KEY_LOW:  r_key_low  <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        if (w_addr_ok) begin
            unique case (w_idx)
                REG_KEY_HIGH: prdata = r_key_high;
                REG_KEY_LOW:  prdata = r_key_low;
                default:      prdata = '0;
            endcase
        end
    end

    // Stage 0: initial AddRoundKey.
    logic   v_valid [NumRounds + 1];
    t_block v_state [NumRounds + 1];
    t_block v_key   [NumRounds + 1];
    logic   r_valid0;
    t_block r_state0, r_key0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid0 <= 1'b0;
        end else begin
            r_valid0 <= i_start;
        end
        r_state0 <= {i_block_high, i_block_low} ^ {r_key_high, r_key_low};
        r_key0   <= {r_key_high, r_key_low};
    end

    assign v_valid[0] = r_valid0;
    assign v_state[0] = r_state0;
    assign v_key[0]   = r_key0;

    for (genvar g = 0; g < NumRounds; g++) begin : g_round
        aes_round #(
            .RCON_VAL (RCON[g]),
            .FINAL_RND(g == NumRounds - 1)
        ) u_round (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_valid(v_valid[g]),
            .i_state(v_state[g]),
            .i_key  (v_key[g]),
            .o_valid(v_valid[g + 1]),
            .o_state(v_state[g + 1]),
            .o_key  (v_key[g + 1])
        );
    end

    assign o_done        = v_valid[NumRounds];
    assign o_cipher_high = v_state[NumRounds][127:64];
    assign o_cipher_low  = v_state[NumRounds][63:0];

    // A result appears on o_done once its item has passed all the round stages.
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(r_valid0, NumRounds) && $past(i_rst_n, NumRounds + 1) |-> o_done)
        else $error("result missing after pipeline latency");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && $past(i_rst_n, NumRounds + 1) |-> $past(i_start, NumRounds + 1))
        else $error("result without an accepted item");

    a_key_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid0 |=> v_key[1] == next_key($past(r_key0), RCON[0]))
        else $error("round key chain broken");
endmodule

FILE: tb/sv/aes128_block_encrypt_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// aes128_block_encrypt_top_test
// Self-checking bench for the AES-128 encryption pipeline. A local cipher
// model predicts each ciphertext from the current key; a scoreboard compares
// every result with the oldest prediction. The key is rewritten between
// phases over APB, including all-zero and all-one keys.
// ----------------------------------------------------------------------------
import aes_pkg::*;

class cipher_scoreboard;
    logic [127:0] pending_q[$];
    int           errors;
    int           checked;

    static function logic [7:0] sb(input logic [7:0] v);
        return SBOX[v];
    endfunction

    static function logic [7:0] dbl(input logic [7:0] v);
        return {v[6:0], 1'b0} ^ (v[7] ? 8'h1b : 8'h00);
    endfunction

    // Byte k of a 128-bit value is bits [127-8k -: 8], state is column major.
    static function logic [127:0] encrypt(input logic [127:0] key, input logic [127:0] pt);
        logic [7:0] st[16];
        logic [7:0] tmp[16];
        logic [7:0] rk[16];
        logic [7:0] t0, t1, t2, t3, rc;
        logic [7:0] a0, a1, a2, a3;
        logic [127:0] ct;
        for (int k = 0; k < 16; k++) begin
            st[k] = pt[127 - 8 * k -: 8];
            rk[k] = key[127 - 8 * k -: 8];
            st[k] ^= rk[k];
        end
        rc = 8'h01;
        for (int r = 1; r <= 10; r++) begin
            for (int c = 0; c < 4; c++)
                for (int w = 0; w < 4; w++)
                    tmp[c * 4 + w] = sb(st[((c + w) % 4) * 4 + w]);
            st = tmp;
            if (r < 10) begin
                for (int c = 0; c < 4; c++) begin
                    a0 = st[c * 4]; a1 = st[c * 4 + 1];
                    a2 = st[c * 4 + 2]; a3 = st[c * 4 + 3];
                    st[c * 4]     = dbl(a0) ^ dbl(a1) ^ a1 ^ a2 ^ a3;
                    st[c * 4 + 1] = a0 ^ dbl(a1) ^ dbl(a2) ^ a2 ^ a3;
                    st[c * 4 + 2] = a0 ^ a1 ^ dbl(a2) ^ dbl(a3) ^ a3;
                    st[c * 4 + 3] = dbl(a0) ^ a0 ^ a1 ^ a2 ^ dbl(a3);
                end
            end
            t0 = sb(rk[13]); t1 = sb(rk[14]); t2 = sb(rk[15]); t3 = sb(rk[12]);
            rk[0] ^= t0 ^ rc; rk[1] ^= t1; rk[2] ^= t2; rk[3] ^= t3;
            for (int k = 4; k < 16; k++) rk[k] ^= rk[k - 4];
            for (int k = 0; k < 16; k++) st[k] ^= rk[k];
            rc = dbl(rc);
        end
        for (int k = 0; k < 16; k++) ct[127 - 8 * k -: 8] = st[k];
        return ct;
    endfunction

    function void note_block(input logic [127:0] key, input logic [127:0] pt);
        pending_q.push_back(encrypt(key, pt));
    endfunction

    function void check_cipher(input logic [63:0] hi, input logic [63:0] lo);
        logic [127:0] exp_ct;
        if (pending_q.size() == 0) begin
            $display("%0t: unexpected ciphertext %h_%h", $time, hi, lo);
            errors++;
            return;
        end
        exp_ct = pending_q.pop_front();
        checked++;
        if (hi !== exp_ct[127:64]) begin
            $display("%0t: cipher_high expected %h actual %h", $time, exp_ct[127:64], hi);
            errors++;
        end
        if (lo !== exp_ct[63:0]) begin
            $display("%0t: cipher_low expected %h actual %h", $time, exp_ct[63:0], lo);
            errors++;
        end
    endfunction
endclass

module aes128_block_encrypt_top_test;
    logic        i_clk;
    logic        i_rst_n;
    logic        i_start;
    logic        o_busy;
    logic [63:0] i_block_high;
    logic [63:0] i_block_low;
    logic        o_done;
    logic [63:0] o_cipher_high;
    logic [63:0] o_cipher_low;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    cipher_scoreboard scb;
    logic [127:0]     cur_key;
    int               blocks_sent;
    int               key_count;

    aes128_block_encrypt_top dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) scb.check_cipher(o_cipher_high, o_cipher_low);
    end

    // The bus returns to idle after each access.
    task automatic write_reg(input t_reg_idx idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= 4'(8 * idx);
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // The pipeline must be empty before the key may change.
    task automatic drain();
        while (scb.pending_q.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_key(input logic [127:0] key);
        drain();
        write_reg(REG_KEY_HIGH, key[127:64]);
        write_reg(REG_KEY_LOW, key[63:0]);
        cur_key = key;
        key_count++;
    endtask

    // Offers one block, after an optional random gap, and holds it until taken.
    task automatic send_block(input logic [127:0] pt, input bit gaps);
        if (gaps) begin
            while ($urandom_range(99) < 34) begin
                i_start <= 1'b0;
                @(posedge i_clk);
            end
        end
        i_start      <= 1'b1;
        i_block_high <= pt[127:64];
        i_block_low  <= pt[63:0];
        do @(posedge i_clk); while (o_busy);
        scb.note_block(cur_key, pt);
        blocks_sent++;
    endtask

    function automatic logic [127:0] rand128();
        return {$urandom, $urandom, $urandom, $urandom};
    endfunction

    initial begin
        logic [127:0] keys[6];
        scb          = new();
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_block_high = '0;
        i_block_low  = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        cur_key      = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset key of zero first, then the standard test vector key.
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        i_start <= 1'b0;
        load_key(128'h000102030405060708090a0b0c0d0e0f);
        send_block(128'h00112233445566778899aabbccddeeff, 1'b0);
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        for (int b = 0; b < 128; b += 16) send_block(128'h1 << b, 1'b0);
        i_start <= 1'b0;
        load_key('1);
        send_block('0, 1'b0);
        send_block('1, 1'b0);
        send_block(128'h8000_0000_0000_0000_0000_0000_0000_0001, 1'b0);
        i_start <= 1'b0;

        keys[0] = 128'h2b7e151628aed2a6abf7158809cf4f3c;
        keys[1] = '0;
        keys[2] = '1;
        keys[3] = rand128();
        keys[4] = rand128();
        keys[5] = rand128();
        for (int p = 0; p < 6; p++) begin
            load_key(keys[p]);
            for (int n = 0; n < 290; n++) begin
                logic [127:0] pt;
                case ($urandom_range(9))
                    0:       pt = ~rand128() & rand128();
                    1:       pt = rand128() | rand128();
                    default: pt = rand128();
                endcase
                // The third phase, under the all-one key, streams back to back with no gaps.
                send_block(pt, p != 2);
                if (n == 150 && p == 4) begin
                    i_start <= 1'b0;
                    drain();
                end
            end
            i_start <= 1'b0;
        end

        drain();
        repeat (20) @(posedge i_clk);
        $display("Covered %0d blocks under %0d keys, %0d ciphertexts checked.",
                 blocks_sent, key_count + 1, scb.checked);
        if (scb.errors == 0 && scb.pending_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
